/* src/bps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Beacon parent selection package
// Shared constants, payload types and the battery penalty function.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Number of entries in the ring of recently seen flood identifiers.
  localparam int SEEN_DEPTH = 16;
  localparam int SeenPtrW   = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int SeenFillW  = $clog2(SEEN_DEPTH + 1);
  localparam int IdW        = 16;

  // Configuration register indexes.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_BATTERY_LEVEL = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BEACON_TYPE   = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_NOT_READY    = 3'd0;
  localparam logic [2:0] ST_INTERFERENCE = 3'd1;
  localparam logic [2:0] ST_WRONG_TYPE   = 3'd2;
  localparam logic [2:0] ST_FIRST_ADOPT  = 3'd3;
  localparam logic [2:0] ST_NEW_BEACON   = 3'd4;
  localparam logic [2:0] ST_DUPLICATE    = 3'd5;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd6;

  // One received beacon.
  typedef struct packed {
    logic             receiver_ready;
    logic             interference;
    logic [7:0]       packet_type;
    logic [7:0]       beacon_hops;
    logic [31:0]      beacon_time;
    logic [IdW-1:0]   beacon_id;
    logic [7:0]       beacon_cost;
    logic [IdW-1:0]   sender_id;
  } bcn_in_t;

  // One result item.
  typedef struct packed {
    logic [2:0]       status;
    logic             route_changed;
    logic             rebroadcast;
    logic [IdW-1:0]   next_hop_out;
    logic [8:0]       hops_out;
    logic [7:0]       cost_out;
    logic [31:0]      time_out;
  } bcn_out_t;

  // Battery penalty step: floor(9 * (100 - battery) / 100), battery clamped
  // to 100. The division by 100 is a multiply by 41 and a shift by 12, which
  // is exact for every product up to 900.
  function automatic logic [3:0] battery_penalty(input logic [6:0] battery);
    logic [6:0]  clamped;
    logic [6:0]  deficit;
    logic [9:0]  scaled;
    logic [15:0] recip;
    begin
      clamped = (battery > 7'd100) ? 7'd100 : battery;
      deficit = 7'd100 - clamped;
      scaled  = 10'(deficit) * 10'd9;
      recip   = 16'(scaled) * 16'd41;
      battery_penalty = recip[15:12];
    end
  endfunction

endpackage
`default_nettype wire

/* src/beacon_parent_selection_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Beacon parent selection unit
// Picks and maintains the mesh parent from received beacons and tracks
// recently seen flood identifiers in a small ring memory.
// ----------------------------------------------------------------------------
// Usage:
// An item (one received beacon) enters on in_valid_i/in_ready_o with its
// fields in in_data_i. Each item yields exactly one result item on
// out_valid_o/out_ready_i, carrying a status code and the route state after
// the beacon has been applied. Configuration (battery level, beacon type
// byte) is written through cfg_we_i/cfg_idx_i/cfg_data_i while no item is
// in flight; the battery penalty is worked out at the write.
// Items are handled one at a time. A rejected beacon, a beacon outside the
// hop window or the first adoption passes through S_EVAL into S_DONE, where
// its result enters the output register, and the next item is taken once
// the unit is back in S_IDLE. A beacon checked against the seen-ID ring
// also passes through S_SEARCH, where it is compared with K ring entries,
// K at most the number of filled entries (itself at most SEEN_DEPTH), one
// after the other, since the memory gives one entry per cycle.
// When the receiver stalls, the waiting result stays in the output register;
// one further item is taken and processed, and its finished result then
// holds the input off until the output register is free. Reset clears the
// route state, the ring fill count and write pointer; ring contents are
// never read before they are written.
// ----------------------------------------------------------------------------
module beacon_parent_selection_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Beacon input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire bps_pkg::bcn_in_t             in_data_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output bps_pkg::bcn_out_t                 out_data_o,
  // Configuration write port.
  input  wire logic                         cfg_we_i,
  input  wire logic [bps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bps_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int PtrW  = bps_pkg::SeenPtrW;
  localparam int FillW = bps_pkg::SeenFillW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e                   state_q;
  bps_pkg::bcn_in_t         in_q;
  bps_pkg::bcn_out_t        out_q;
  logic                     out_valid_q;

  logic                     have_route_q;
  logic [8:0]               hop_q;
  logic [7:0]               base_cost_q;
  logic [7:0]               own_cost_q;
  logic [bps_pkg::IdW-1:0]  parent_q;
  logic [31:0]              time_q;
  logic [FillW-1:0]         fill_q;
  logic [PtrW-1:0]          wr_ptr_q;
  logic [PtrW-1:0]          srch_idx_q;
  logic [2:0]               status_q;
  logic                     changed_q;
  logic                     rebro_q;

  logic [3:0]               pen_q;
  logic [7:0]               type_code_q;

  logic                     accept_in;
  logic                     out_load;
  logic                     rejected;
  logic [2:0]               reject_code;
  logic                     same_parent;
  logic                     upd_route;
  logic [8:0]               hop_new;
  logic [8:0]               hop_nxt;
  logic                     in_window;
  logic [7:0]               cost_new;
  logic                     go_search;
  logic                     srch_match;
  logic                     srch_last;
  logic [FillW-1:0]         srch_next;
  logic                     rec_now;
  logic [PtrW-1:0]          wr_ptr_nxt;
  logic                     ram_re;
  logic [PtrW-1:0]          ram_raddr;
  logic [bps_pkg::IdW-1:0]  ram_rdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers; the penalty is derived once per battery write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= 4'd0;
      type_code_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bps_pkg::CFG_BATTERY_LEVEL: pen_q <= bps_pkg::battery_penalty(cfg_data_i[6:0]);
        bps_pkg::CFG_BEACON_TYPE:   type_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Filtering of the beacon held in the input register.
  always_comb begin
    rejected    = 1'b1;
    reject_code = bps_pkg::ST_NOT_READY;
    priority if (!in_q.receiver_ready) begin
      reject_code = bps_pkg::ST_NOT_READY;
    end else if (in_q.interference) begin
      reject_code = bps_pkg::ST_INTERFERENCE;
    end else if (in_q.packet_type != type_code_q) begin
      reject_code = bps_pkg::ST_WRONG_TYPE;
    end else begin
      rejected = 1'b0;
    end
  end

  // Route update decision and hop window test on the updated hop count.
  assign same_parent = (parent_q == in_q.sender_id);
  assign upd_route   = same_parent ? (base_cost_q < in_q.beacon_cost)
                                   : (base_cost_q > in_q.beacon_cost);
  assign hop_new     = {1'b0, in_q.beacon_hops} + 9'd1;
  assign hop_nxt     = upd_route ? hop_new : hop_q;
  assign in_window   = ({1'b0, hop_nxt} + 10'd4) > {2'b00, in_q.beacon_hops};
  assign cost_new    = in_q.beacon_cost + {2'b00, pen_q, 2'b00};

  // Seen-ID search: the entry read in the previous cycle is compared now.
  assign go_search  = (fill_q != '0);
  assign srch_next  = FillW'(srch_idx_q) + FillW'(1);
  assign srch_match = (ram_rdata == in_q.beacon_id);
  assign srch_last  = (srch_next == fill_q);

  // A new identifier is written at once when the ring is empty or the route
  // is first adopted, otherwise after a search that found no match. Writes
  // and reads of one item never overlap, and the next item's reads start only
  // after S_DONE and S_IDLE have passed, so no forwarding is needed.
  always_comb begin
    rec_now = 1'b0;
    if (state_q == S_EVAL && !rejected) begin
      rec_now = !have_route_q || (in_window && !go_search);
    end else if (state_q == S_SEARCH) begin
      rec_now = !srch_match && srch_last;
    end
  end

  assign wr_ptr_nxt = (wr_ptr_q == PtrW'(bps_pkg::SEEN_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == S_EVAL) begin
      ram_re = !rejected && have_route_q && in_window && go_search;
    end else if (state_q == S_SEARCH) begin
      ram_re    = !srch_match && !srch_last;
      ram_raddr = srch_next[PtrW-1:0];
    end
  end

  bps_ram #(
    .Width (bps_pkg::IdW),
    .Depth (bps_pkg::SEEN_DEPTH)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (rec_now),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_q.beacon_id),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Payload registers for the input item and the result item.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q.status        <= status_q;
      out_q.route_changed <= changed_q;
      out_q.rebroadcast   <= rebro_q;
      out_q.next_hop_out  <= parent_q;
      out_q.hops_out      <= hop_q;
      out_q.cost_out      <= own_cost_q;
      out_q.time_out      <= time_q;
    end
  end

  // Sequencer, route state and ring bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      have_route_q <= 1'b0;
      hop_q        <= 9'd0;
      base_cost_q  <= 8'd0;
      own_cost_q   <= 8'd0;
      parent_q     <= '0;
      time_q       <= 32'd0;
      fill_q       <= '0;
      wr_ptr_q     <= '0;
      srch_idx_q   <= '0;
      status_q     <= bps_pkg::ST_NOT_READY;
      changed_q    <= 1'b0;
      rebro_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (rec_now) begin
        wr_ptr_q <= wr_ptr_nxt;
        if (fill_q != FillW'(bps_pkg::SEEN_DEPTH)) begin
          fill_q <= fill_q + FillW'(1);
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            state_q   <= S_EVAL;
            changed_q <= 1'b0;
            rebro_q   <= 1'b0;
          end
        end

        S_EVAL: begin
          state_q <= S_DONE;
          priority if (rejected) begin
            status_q <= reject_code;
          end else if (!have_route_q) begin
            // First usable beacon: adopt its sender outright.
            have_route_q <= 1'b1;
            hop_q        <= hop_new;
            time_q       <= in_q.beacon_time;
            base_cost_q  <= in_q.beacon_cost;
            own_cost_q   <= cost_new;
            parent_q     <= in_q.sender_id;
            changed_q    <= 1'b1;
            rebro_q      <= 1'b1;
            status_q     <= bps_pkg::ST_FIRST_ADOPT;
          end else begin
            if (upd_route) begin
              hop_q       <= hop_new;
              base_cost_q <= in_q.beacon_cost;
              own_cost_q  <= cost_new;
              parent_q    <= in_q.sender_id;
              changed_q   <= !same_parent;
            end
            if (in_window) begin
              time_q <= in_q.beacon_time;
              if (go_search) begin
                state_q    <= S_SEARCH;
                srch_idx_q <= '0;
              end else begin
                rebro_q  <= 1'b1;
                status_q <= bps_pkg::ST_NEW_BEACON;
              end
            end else begin
              status_q <= bps_pkg::ST_OUT_OF_RANGE;
            end
          end
        end

        S_SEARCH: begin
          if (srch_match) begin
            status_q <= bps_pkg::ST_DUPLICATE;
            state_q  <= S_DONE;
          end else if (srch_last) begin
            rebro_q  <= 1'b1;
            status_q <= bps_pkg::ST_NEW_BEACON;
            state_q  <= S_DONE;
          end else begin
            srch_idx_q <= srch_idx_q + PtrW'(1);
          end
        end

        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/bps_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module bps_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/bps_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Beacon parent selection checker
// Port-level properties of the beacon parent selection unit, bound to it.
// ----------------------------------------------------------------------------
module bps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire bps_pkg::bcn_out_t            out_data_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  else $error("result item changed or dropped while stalled");

  // Items are processed one at a time: no second item right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
  else $error("input taken on consecutive cycles");

  // A rebroadcast is asked for exactly on a first adoption or a new flood.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rebroadcast ==
      (out_data_o.status == bps_pkg::ST_FIRST_ADOPT ||
       out_data_o.status == bps_pkg::ST_NEW_BEACON))
  else $error("rebroadcast flag disagrees with status");

  // A changed route only comes from a beacon that passed the filters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.route_changed |->
      (out_data_o.status == bps_pkg::ST_FIRST_ADOPT ||
       out_data_o.status == bps_pkg::ST_NEW_BEACON ||
       out_data_o.status == bps_pkg::ST_DUPLICATE) && out_data_o.hops_out != 9'd0)
  else $error("route changed on a rejected or out-of-window beacon");

endmodule

bind beacon_parent_selection_unit bps_checker u_bps_checker (.*);
`default_nettype wire

/* tb/sv/tb_beacon_parent_selection_unit.sv */
// ----------------------------------------------------------------------------
// Beacon parent selection unit testbench
// Drives received beacons through the valid/ready input channel, predicts
// each result item from a behavioural copy of the parent selection logic and
// compares every result field by field. A short table of directed beacons
// comes first, then random traffic in phases with different battery levels
// and beacon type codes, random idling on both sides, one long receiver
// hold-off and several pauses that let the unit drain completely.
// ----------------------------------------------------------------------------
module tb_beacon_parent_selection_unit;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * (3 + bps_pkg::SEEN_DEPTH) + 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 105;
  localparam int HISTORY_KEEP = 24;
  localparam int REPORT_MAX   = 10;

  // Row of the directed table: a beacon and, where typed, its result.
  typedef struct packed {
    bps_pkg::bcn_in_t  beacon;
    logic              typed;
    bps_pkg::bcn_out_t result;
  } bcn_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  bps_pkg::bcn_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  bps_pkg::bcn_out_t            out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic [bps_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [bps_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  // Copy of the node's route state and configuration.
  logic [6:0]  node_battery   = 7'd100;
  logic [7:0]  node_type_code = 8'd0;
  logic        node_has_route = 1'b0;
  logic [8:0]  node_hops      = '0;
  logic [7:0]  node_base_cost = '0;
  logic [7:0]  node_cost      = '0;
  logic [15:0] node_parent    = '0;
  logic [31:0] node_time      = '0;
  logic [15:0] seen_ring [bps_pkg::SEEN_DEPTH];
  int          seen_count     = 0;
  int          seen_wr        = 0;

  bps_pkg::bcn_out_t route_expect_q [$];
  bcn_row_t          dir_rows [$];
  logic [15:0]       recent_ids [$];

  int  cycle_cnt      = 0;
  int  mismatch_cnt   = 0;
  int  beacons_sent   = 0;
  int  results_seen   = 0;
  int  status_tally [8];
  int  hold_left      = 0;
  int  stall_left     = 0;
  logic hold_pending  = 1'b0;
  logic hold_done     = 1'b0;
  logic steady_run    = 1'b0;

  beacon_parent_selection_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a period of 8 time units.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bps_pkg::bcn_in_t make_beacon(input logic ready, input logic intf,
                                                   input logic [7:0] ptype,
                                                   input logic [7:0] hops,
                                                   input logic [31:0] stamp,
                                                   input logic [15:0] id,
                                                   input logic [7:0] cost,
                                                   input logic [15:0] sender);
    bps_pkg::bcn_in_t b;
    b.receiver_ready = ready;
    b.interference   = intf;
    b.packet_type    = ptype;
    b.beacon_hops    = hops;
    b.beacon_time    = stamp;
    b.beacon_id      = id;
    b.beacon_cost    = cost;
    b.sender_id      = sender;
    return b;
  endfunction

  function automatic bps_pkg::bcn_out_t make_result(input logic [2:0] status,
                                                    input logic changed,
                                                    input logic rebro,
                                                    input logic [15:0] parent,
                                                    input logic [8:0] hops,
                                                    input logic [7:0] cost,
                                                    input logic [31:0] stamp);
    bps_pkg::bcn_out_t r;
    r.status        = status;
    r.route_changed = changed;
    r.rebroadcast   = rebro;
    r.next_hop_out  = parent;
    r.hops_out      = hops;
    r.cost_out      = cost;
    r.time_out      = stamp;
    return r;
  endfunction

  task automatic add_row(input bps_pkg::bcn_in_t b, input logic typed,
                         input bps_pkg::bcn_out_t r);
    bcn_row_t row;
    row.beacon = b;
    row.typed  = typed;
    row.result = r;
    dir_rows   = {dir_rows, row};
  endtask

  // Advertised cost: the beacon's cost plus four times the battery step,
  // with the battery clamped to one hundred and the sum wrapping at 8 bits.
  function automatic logic [7:0] penalised_cost(input logic [7:0] cost);
    int unsigned bat;
    int unsigned step;
    bat  = (node_battery > 7'd100) ? 100 : node_battery;
    step = (9 * (100 - bat)) / 100;
    return 8'(cost + 4 * step);
  endfunction

  // Flood IDs go into a ring that overwrites its oldest entry when full.
  function automatic void remember_id(input logic [15:0] id);
    seen_ring[seen_wr] = id;
    seen_wr = (seen_wr + 1) % bps_pkg::SEEN_DEPTH;
    if (seen_count < bps_pkg::SEEN_DEPTH) seen_count++;
  endfunction

  // Applies one accepted beacon to the route state and returns its result.
  function automatic bps_pkg::bcn_out_t apply_beacon(input bps_pkg::bcn_in_t b);
    bps_pkg::bcn_out_t res;
    logic              known;
    res = '0;
    known = 1'b0;
    if (!b.receiver_ready) begin
      res.status = bps_pkg::ST_NOT_READY;
    end else if (b.interference) begin
      res.status = bps_pkg::ST_INTERFERENCE;
    end else if (b.packet_type != node_type_code) begin
      res.status = bps_pkg::ST_WRONG_TYPE;
    end else if (!node_has_route) begin
      node_has_route = 1'b1;
      node_hops      = {1'b0, b.beacon_hops} + 9'd1;
      node_time      = b.beacon_time;
      remember_id(b.beacon_id);
      node_base_cost = b.beacon_cost;
      node_cost      = penalised_cost(b.beacon_cost);
      node_parent    = b.sender_id;
      res.route_changed = 1'b1;
      res.rebroadcast   = 1'b1;
      res.status        = bps_pkg::ST_FIRST_ADOPT;
    end else begin
      // The current parent may only raise its cost; another node must be cheaper.
      if (node_parent == b.sender_id) begin
        if (node_base_cost < b.beacon_cost) begin
          node_cost      = penalised_cost(b.beacon_cost);
          node_base_cost = b.beacon_cost;
          node_hops      = {1'b0, b.beacon_hops} + 9'd1;
        end
      end else if (node_base_cost > b.beacon_cost) begin
        node_cost      = penalised_cost(b.beacon_cost);
        node_base_cost = b.beacon_cost;
        node_hops      = {1'b0, b.beacon_hops} + 9'd1;
        node_parent    = b.sender_id;
        res.route_changed = 1'b1;
      end
      // Hop window check uses the hop count after any update above.
      if (int'(node_hops) + 4 > int'(b.beacon_hops)) begin
        node_time = b.beacon_time;
        for (int i = 0; i < seen_count; i++) begin
          if (seen_ring[i] == b.beacon_id) known = 1'b1;
        end
        if (known) begin
          res.status = bps_pkg::ST_DUPLICATE;
        end else begin
          remember_id(b.beacon_id);
          res.rebroadcast = 1'b1;
          res.status      = bps_pkg::ST_NEW_BEACON;
        end
      end else begin
        res.status = bps_pkg::ST_OUT_OF_RANGE;
      end
    end
    res.next_hop_out = node_parent;
    res.hops_out     = node_hops;
    res.cost_out     = node_cost;
    res.time_out     = node_time;
    return res;
  endfunction

  // Random beacon: mostly well-formed, aimed at the current route so that
  // switches, cost rises, the hop window edge and duplicate IDs all occur.
  function automatic bps_pkg::bcn_in_t draw_beacon();
    int          pick;
    int          h;
    int          c;
    int          who;
    logic [7:0]  ptype;
    logic [15:0] id;
    logic [15:0] sender;
    pick  = int'($urandom_range(0, 99));
    ptype = node_type_code;
    if (pick >= 8 && pick < 14) begin
      do ptype = 8'($urandom_range(0, 255)); while (ptype == node_type_code);
    end
    if ($urandom_range(0, 99) < 65) begin
      h = int'(node_hops) - 6 + int'($urandom_range(0, 12));
      h = (h < 0) ? 0 : ((h > 255) ? 255 : h);
    end else begin
      h = int'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < 55) begin
      c = int'(node_base_cost) - 3 + int'($urandom_range(0, 6));
      c = (c < 0) ? 0 : ((c > 255) ? 255 : c);
    end else begin
      c = int'($urandom_range(0, 255));
    end
    who = int'($urandom_range(0, 99));
    sender = (who < 40) ? node_parent :
             (who < 80) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
    if (recent_ids.size() > 0 && $urandom_range(0, 99) < 50) begin
      id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end else begin
      id = 16'($urandom_range(0, 65535));
    end
    recent_ids = {recent_ids, id};
    if (recent_ids.size() > HISTORY_KEEP) void'(recent_ids.pop_front());
    return make_beacon(pick >= 4, pick >= 4 && pick < 8, ptype, 8'(h), $urandom(), id,
                       8'(c), sender);
  endfunction

  // Gap before the next item: mostly short, now and then long.
  function automatic int idle_gap();
    int pick;
    if (steady_run) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beacon and records its expected result once it is accepted.
  task automatic offer_beacon(input bps_pkg::bcn_in_t b, input logic typed,
                              input bps_pkg::bcn_out_t typed_res, input int gap);
    bps_pkg::bcn_out_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predicted = apply_beacon(b);
    if (typed) predicted = typed_res;
    route_expect_q = {route_expect_q, predicted};
    beacons_sent++;
  endtask

  // Holds the sender back until every expected result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (route_expect_q.size() != 0);
  endtask

  // Writes both registers on consecutive cycles while the unit is idle.
  task automatic program_node_config(input logic [7:0] battery, input logic [7:0] code);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bps_pkg::CFG_BATTERY_LEVEL;
    cfg_data_i <= battery;
    @(posedge clk_i);
    node_battery = battery[6:0];
    cfg_idx_i  <= bps_pkg::CFG_BEACON_TYPE;
    cfg_data_i <= code;
    @(posedge clk_i);
    node_type_code = code;
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (exp !== act) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 results_seen, name, exp, act);
    end
  endtask

  // Receiver: random stalls, occasional long ones, and one long hold-off.
  always @(posedge clk_i) begin
    int pick;
    if (hold_pending && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady_run) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      pick = int'($urandom_range(0, 99));
      if (pick < 65) begin
        out_ready_i <= 1'b1;
      end else if (pick < 96) begin
        out_ready_i <= 1'b0;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Result checker: each accepted result item against the oldest expectation.
  always @(posedge clk_i) begin
    bps_pkg::bcn_out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      status_tally[out_data_o.status]++;
      if (route_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("Unexpected result %0d with status %0d", results_seen,
                   out_data_o.status);
      end else begin
        exp = route_expect_q.pop_front();
        check_field("status", 32'(exp.status), 32'(out_data_o.status));
        check_field("route_changed", 32'(exp.route_changed),
                    32'(out_data_o.route_changed));
        check_field("rebroadcast", 32'(exp.rebroadcast), 32'(out_data_o.rebroadcast));
        check_field("next_hop_out", 32'(exp.next_hop_out),
                    32'(out_data_o.next_hop_out));
        check_field("hops_out", 32'(exp.hops_out), 32'(out_data_o.hops_out));
        check_field("cost_out", 32'(exp.cost_out), 32'(out_data_o.cost_out));
        check_field("time_out", exp.time_out, out_data_o.time_out);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("beacon_parent_selection_unit verification failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    bcn_row_t row;
    logic [7:0] bat;
    logic [7:0] code;

    // Directed table, run with the reset configuration (battery 100, type 0).
    // Rejections before any route show all-zero state.
    add_row(make_beacon(1'b0, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                        16'hFFFF), 1'b1,
            make_result(bps_pkg::ST_NOT_READY, 1'b0, 1'b0, 16'h0, 9'd0, 8'h0, 32'h0));
    add_row(make_beacon(1'b1, 1'b1, 8'h00, 8'h00, 32'h0, 16'h0, 8'h00, 16'h0), 1'b1,
            make_result(bps_pkg::ST_INTERFERENCE, 1'b0, 1'b0, 16'h0, 9'd0, 8'h0, 32'h0));
    add_row(make_beacon(1'b1, 1'b0, 8'hFF, 8'h01, 32'h1, 16'h1, 8'h01, 16'h1), 1'b1,
            make_result(bps_pkg::ST_WRONG_TYPE, 1'b0, 1'b0, 16'h0, 9'd0, 8'h0, 32'h0));
    add_row(make_beacon(1'b1, 1'b0, 8'h80, 8'h01, 32'h1, 16'h1, 8'h01, 16'h1), 1'b1,
            make_result(bps_pkg::ST_WRONG_TYPE, 1'b0, 1'b0, 16'h0, 9'd0, 8'h0, 32'h0));
    // First adoption at the field extremes: hop count reaches 256.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF,
                        16'hFFFF), 1'b1,
            make_result(bps_pkg::ST_FIRST_ADOPT, 1'b1, 1'b1, 16'hFFFF, 9'd256, 8'hFF,
                        32'hFFFF_FFFF));
    // Same parent, cheaper: no change, and the adopted ID is a duplicate.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h00, 32'h0, 16'hFFFF, 8'h00, 16'hFFFF),
            1'b0, '0);
    // Rejection once a route exists shows the current state.
    add_row(make_beacon(1'b0, 1'b0, 8'h00, 8'h00, 32'h5, 16'h5, 8'h00, 16'h5), 1'b0, '0);
    // Cheaper sender takes over.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h00, 32'h1234_5678, 16'h0000, 8'h00,
                        16'h0000), 1'b0, '0);
    // Parent raises its cost.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h0A, 32'hA5A5_A5A5, 16'h0001, 8'hC8,
                        16'h0000), 1'b0, '0);
    // Equal cost from another node does not switch; beacon outside the window.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h14, 32'h5A5A_5A5A, 16'h0002, 8'hC8,
                        16'h0005), 1'b0, '0);
    // Hop window edges: hop count 11, so 14 is inside and 15 outside.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h0E, 32'h0F0F_0F0F, 16'h0001, 8'hFF,
                        16'h0007), 1'b0, '0);
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h0F, 32'hF0F0_F0F0, 16'h0003, 8'hFF,
                        16'h0007), 1'b0, '0);
    // Parent lowering its cost is ignored for the route.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h03, 32'h0000_FFFF, 16'h0003, 8'h32,
                        16'h0000), 1'b0, '0);
    // Switch by a margin of one.
    add_row(make_beacon(1'b1, 1'b0, 8'h00, 8'h80, 32'hFFFF_0000, 16'h8000, 8'hC7,
                        16'h1234), 1'b0, '0);
    // Not ready takes precedence over interference and a wrong type.
    add_row(make_beacon(1'b0, 1'b1, 8'h7F, 8'h00, 32'h0, 16'h0, 8'h00, 16'h0), 1'b0, '0);
    add_row(make_beacon(1'b1, 1'b1, 8'h7F, 8'h00, 32'h0, 16'h0, 8'h00, 16'h0), 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      offer_beacon(row.beacon, row.typed, row.result, idle_gap());
    end
    wait_drained();

    // Random phases, each with its own configuration.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin bat = 8'd0;   code = 8'hA5; end
        1:       begin bat = 8'hFF;  code = 8'hFF; end
        2:       begin bat = 8'd1;   code = 8'h00; end
        3:       begin bat = 8'd88;  code = 8'h5A; end
        4:       begin bat = 8'd100; code = 8'($urandom_range(0, 255)); end
        default: begin
          bat  = 8'($urandom_range(0, 127));
          code = 8'($urandom_range(0, 255));
        end
      endcase
      program_node_config(bat, code);
      steady_run <= (ph == 1);
      // Long receiver hold-off while the sender keeps offering items.
      if (ph == 2) hold_pending <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_beacon(draw_beacon(), 1'b0, '0, idle_gap());
        if (!steady_run && $urandom_range(0, 49) == 0) wait_drained();
      end
      wait_drained();
    end

    steady_run <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d beacons in %0d cycles, checked %0d results, %0d mismatches.",
             beacons_sent, cycle_cnt, results_seen, mismatch_cnt);
    $display("Rejects %0d/%0d/%0d, adopts %0d, new %0d, duplicates %0d, outside %0d.",
             status_tally[bps_pkg::ST_NOT_READY], status_tally[bps_pkg::ST_INTERFERENCE],
             status_tally[bps_pkg::ST_WRONG_TYPE], status_tally[bps_pkg::ST_FIRST_ADOPT],
             status_tally[bps_pkg::ST_NEW_BEACON], status_tally[bps_pkg::ST_DUPLICATE],
             status_tally[bps_pkg::ST_OUT_OF_RANGE]);
    if (mismatch_cnt == 0 && route_expect_q.size() == 0) begin
      $display("beacon_parent_selection_unit verification clean");
    end else begin
      $display("beacon_parent_selection_unit verification failed");
    end
    $finish;
  end

endmodule
